// ===== design/eftec_pkg.sv =====
// ---------------------------------------------------------------------------
// eftec_pkg
// Types, constants and helper functions for the tolerant equality compare
// of two x87 80-bit extended values.
// ---------------------------------------------------------------------------
`default_nettype none

package eftec_pkg;

    localparam int SE_W   = 16;
    localparam int SIG_W  = 64;
    localparam int EXP_W  = 17;
    localparam int WIDE_W = 128;
    localparam int DEPTH  = 8;

    localparam logic REG_TOL_SE  = 1'b0;
    localparam logic REG_TOL_SIG = 1'b1;

    localparam logic [14:0] EX_MAX = 15'h7fff;
    localparam logic [SIG_W-1:0] TOPBIT = {1'b1, {(SIG_W-1){1'b0}}};

    typedef enum logic [1:0] {
        CL_ZERO = 2'd0,
        CL_FIN  = 2'd1,
        CL_INF  = 2'd2,
        CL_NAN  = 2'd3
    } cls_t;

    typedef struct packed {
        cls_t              cls;
        logic              sgn;
        logic [14:0]       ex;
        logic [SIG_W-1:0]  m;
        logic [5:0]        lz;
    } dec_t;

    typedef struct packed {
        cls_t                    cls;
        logic                    sgn;
        logic [SIG_W-1:0]        m;
        logic signed [EXP_W-1:0] e;
    } xval_t;

    function automatic logic [5:0] lzc64(input logic [63:0] v);
        logic [5:0] r;
        r = '0;
        for (int i = 0; i < 64; i++)
        begin
            if (v[i])
            begin
                r = 6'(63 - i);
            end
        end
        return r;
    endfunction

    function automatic logic [6:0] lzc128(input logic [127:0] v);
        logic [6:0] r;
        r = '0;
        for (int i = 0; i < 128; i++)
        begin
            if (v[i])
            begin
                r = 7'(127 - i);
            end
        end
        return r;
    endfunction

    function automatic dec_t classify(input logic [SE_W-1:0] se, input logic [SIG_W-1:0] m);
        dec_t d;
        d.sgn = se[15];
        d.ex  = se[14:0];
        d.m   = m;
        d.lz  = lzc64(m);
        if (d.ex == EX_MAX)
        begin
            d.cls = (m == TOPBIT) ? CL_INF : CL_NAN;
        end
        else if (d.ex == 15'd0)
        begin
            if (m == '0)
            begin
                d.cls = CL_ZERO;
            end
            else if (m[SIG_W-1])
            begin
                d.cls = CL_NAN;
            end
            else
            begin
                d.cls = CL_FIN;
            end
        end
        else if (!m[SIG_W-1])
        begin
            d.cls = CL_NAN;
        end
        else
        begin
            d.cls = CL_FIN;
        end
        return d;
    endfunction

    function automatic xval_t normalise(input dec_t d);
        xval_t x;
        x.cls = d.cls;
        x.sgn = d.sgn;
        x.m   = d.m;
        x.e   = '0;
        if (d.cls == CL_FIN)
        begin
            if (d.ex == 15'd0)
            begin
                x.m = d.m << d.lz;
                x.e = -17'sd16381 - $signed({11'b0, d.lz});
            end
            else
            begin
                x.e = $signed({2'b00, d.ex}) - 17'sd16382;
            end
        end
        return x;
    endfunction

    function automatic logic at_most_one(input xval_t x);
        return (x.cls == CL_ZERO) || (x.e <= 17'sd0) || ((x.e == 17'sd1) && (x.m == TOPBIT));
    endfunction

endpackage : eftec_pkg

`default_nettype wire

// ===== design/extended_float_tolerant_equal_core.sv =====
// ---------------------------------------------------------------------------
// extended_float_tolerant_equal_core
// Tolerant equality of two x87 80-bit extended values against a configured
// tolerance, computed in an eight-stage pipeline.
// ---------------------------------------------------------------------------
// One pair of values is taken every clock cycle unless in_stall is high, and
// its equal flag waits in the last stage while the output is stalled. The
// eight stages are classify with leading-zero count, normalise, rule
// selection and ordering, alignment shift, 128-bit add or subtract,
// leading-zero count, round, and the tolerance compare. A stall on the output
// holds each stage only as far back as the first empty stage.
`default_nettype none

module extended_float_tolerant_equal_core (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic [eftec_pkg::SE_W-1:0]  a_sign_exponent,
    input  wire logic [eftec_pkg::SIG_W-1:0] a_significand,
    input  wire logic [eftec_pkg::SE_W-1:0]  b_sign_exponent,
    input  wire logic [eftec_pkg::SIG_W-1:0] b_significand,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic                             equal,
    input  wire logic                        cfg_write,
    input  wire logic                        cfg_index,
    input  wire logic [eftec_pkg::SIG_W-1:0] cfg_data
);
    import eftec_pkg::*;

    logic [SE_W-1:0]  tol_se_reg;
    logic [SIG_W-1:0] tol_sig_reg;
    xval_t            tol_reg;
    xval_t            tol_next;

    logic [DEPTH:1] v_reg;
    logic [DEPTH+1:1] adv;

    // Stage 1
    dec_t s1_a_reg, s1_b_reg;
    // Stage 2
    xval_t s2_a_reg, s2_b_reg;
    // Stage 3
    logic                    s3_direct_reg, s3_dval_reg, s3_kbig_reg, s3_sub_reg;
    logic [6:0]              s3_k_reg;
    logic [SIG_W-1:0]        s3_am_reg, s3_bm_reg;
    logic signed [EXP_W-1:0] s3_ae_reg;
    // Stage 4
    logic                    s4_direct_reg, s4_dval_reg, s4_sub_reg;
    logic [SIG_W-1:0]        s4_am_reg;
    logic [WIDE_W-1:0]       s4_b_reg;
    logic signed [EXP_W-1:0] s4_ae_reg;
    // Stage 5
    logic                    s5_direct_reg, s5_dval_reg;
    logic [WIDE_W-1:0]       s5_sum_reg;
    logic signed [EXP_W-1:0] s5_ae_reg;
    // Stage 6
    logic                    s6_direct_reg, s6_dval_reg, s6_zero_reg;
    logic [WIDE_W-1:0]       s6_sum_reg;
    logic [6:0]              s6_l_reg;
    logic signed [EXP_W-1:0] s6_ae_reg;
    // Stage 7
    logic                    s7_direct_reg, s7_dval_reg, s7_nz_reg;
    logic [SIG_W-1:0]        s7_mr_reg;
    logic signed [EXP_W-1:0] s7_re_reg;
    // Stage 8
    logic equal_reg;

    // Configuration and tolerance decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_se_reg  <= '0;
            tol_sig_reg <= '0;
            tol_reg     <= '{cls: CL_ZERO, sgn: 1'b0, m: '0, e: '0};
        end
        else
        begin
            if (cfg_write && (cfg_index == REG_TOL_SE))
            begin
                tol_se_reg <= cfg_data[SE_W-1:0];
            end
            if (cfg_write && (cfg_index == REG_TOL_SIG))
            begin
                tol_sig_reg <= cfg_data;
            end
            tol_reg <= tol_next;
        end
    end

    assign tol_next = normalise(classify(tol_se_reg, tol_sig_reg));

    // Stage advance chain.
    always_comb
    begin
        adv[DEPTH+1] = !out_stall;
        for (int i = DEPTH; i >= 1; i--)
        begin
            adv[i] = !v_reg[i] || adv[i+1];
        end
    end

    assign in_stall  = !adv[1];
    assign out_valid = v_reg[DEPTH];
    assign equal     = equal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int i = 1; i <= DEPTH; i++)
            begin
                if (adv[i])
                begin
                    v_reg[i] <= (i == 1) ? in_valid : v_reg[i-1];
                end
            end
        end
    end

    // Stage 3 combinational: rule selection, rescale and ordering.
    logic                    c3_direct, c3_dval, c3_rescale, c3_x_ge;
    logic signed [EXP_W:0]   c3_dab, c3_k;
    logic signed [EXP_W-1:0] c3_ea, c3_eb;
    xval_t                   c3_hi, c3_lo;
    logic                    c3_az, c3_bz;

    always_comb
    begin
        c3_direct  = 1'b1;
        c3_dval    = 1'b0;
        c3_rescale = 1'b0;
        c3_dab     = EXP_W'(0) + ((EXP_W+1)'(s2_a_reg.e) - (EXP_W+1)'(s2_b_reg.e));
        if ((s2_a_reg.cls == CL_NAN) && (s2_b_reg.cls == CL_NAN))
        begin
            c3_dval = 1'b1;
        end
        else if ((s2_a_reg.cls == CL_NAN) || (s2_b_reg.cls == CL_NAN))
        begin
            c3_dval = 1'b0;
        end
        else if ((s2_a_reg.cls == CL_INF) && (s2_b_reg.cls == CL_INF))
        begin
            c3_dval = (s2_a_reg.sgn == s2_b_reg.sgn);
        end
        else if ((s2_a_reg.cls == CL_INF) || (s2_b_reg.cls == CL_INF))
        begin
            c3_dval = 1'b0;
        end
        else if (at_most_one(s2_a_reg) && at_most_one(s2_b_reg))
        begin
            c3_direct = 1'b0;
        end
        else if (s2_a_reg.sgn != s2_b_reg.sgn)
        begin
            c3_dval = 1'b0;
        end
        else if ((c3_dab > 18'sd1) || (c3_dab < -18'sd1))
        begin
            c3_dval = 1'b0;
        end
        else
        begin
            c3_direct  = 1'b0;
            c3_rescale = 1'b1;
        end

        c3_ea = s2_a_reg.e;
        c3_eb = s2_b_reg.e;
        if (c3_rescale)
        begin
            c3_ea = (c3_dab < 18'sd0) ? '0 : c3_dab[EXP_W-1:0];
            c3_eb = (c3_dab < 18'sd0) ? -c3_dab[EXP_W-1:0] : '0;
        end

        c3_az   = (s2_a_reg.cls == CL_ZERO);
        c3_bz   = (s2_b_reg.cls == CL_ZERO);
        c3_x_ge = c3_bz || (!c3_az && ((c3_ea > c3_eb) ||
                  ((c3_ea == c3_eb) && (s2_a_reg.m >= s2_b_reg.m))));
        c3_hi   = s2_a_reg;
        c3_lo   = s2_b_reg;
        c3_hi.e = c3_ea;
        c3_lo.e = c3_eb;
        if (!c3_x_ge)
        begin
            c3_hi   = s2_b_reg;
            c3_lo   = s2_a_reg;
            c3_hi.e = c3_eb;
            c3_lo.e = c3_ea;
        end
        if (c3_hi.cls == CL_ZERO)
        begin
            c3_hi.m = '0;
        end
        if (c3_lo.cls == CL_ZERO)
        begin
            c3_lo.m = '0;
        end
        c3_k = (EXP_W+1)'(c3_hi.e) - (EXP_W+1)'(c3_lo.e);
    end

    // Stage 4 combinational: alignment with sticky bit.
    logic [WIDE_W-1:0] c4_bfull, c4_sh;
    logic              c4_st;

    always_comb
    begin
        c4_bfull = {1'b0, s3_bm_reg, {(SIG_W-1){1'b0}}};
        if (s3_kbig_reg)
        begin
            c4_sh = '0;
            c4_st = |s3_bm_reg;
        end
        else
        begin
            c4_sh = c4_bfull >> s3_k_reg;
            c4_st = |(c4_bfull & ~({WIDE_W{1'b1}} << s3_k_reg));
        end
    end

    // Stage 5 combinational: add or subtract.
    logic [WIDE_W-1:0] c5_a, c5_sum;

    assign c5_a   = {1'b0, s4_am_reg, {(SIG_W-1){1'b0}}};
    assign c5_sum = s4_sub_reg ? (c5_a - s4_b_reg) : (c5_a + s4_b_reg);

    // Stage 7 combinational: normalise and round to nearest-even.
    logic [WIDE_W-1:0] c7_n;
    logic [SIG_W-1:0]  c7_mr;
    logic              c7_inc, c7_pinc;

    always_comb
    begin
        c7_n    = s6_sum_reg << s6_l_reg;
        c7_inc  = c7_n[SIG_W-1] && ((|c7_n[SIG_W-2:0]) || c7_n[SIG_W]);
        c7_pinc = c7_inc && (&c7_n[WIDE_W-1:SIG_W]);
        c7_mr   = c7_pinc ? TOPBIT : (c7_n[WIDE_W-1:SIG_W] + SIG_W'(c7_inc));
    end

    // Stage 8 combinational: tolerance compare against twice eps.
    logic                    c8_within;
    logic signed [EXP_W-1:0] c8_te;

    always_comb
    begin
        c8_te = tol_reg.e + 17'sd1;
        case (tol_reg.cls)
            CL_NAN:  c8_within = 1'b0;
            CL_INF:  c8_within = !tol_reg.sgn;
            CL_ZERO: c8_within = !s7_nz_reg;
            CL_FIN:
            begin
                if (tol_reg.sgn)
                begin
                    c8_within = 1'b0;
                end
                else if (!s7_nz_reg)
                begin
                    c8_within = 1'b1;
                end
                else
                begin
                    c8_within = (s7_re_reg < c8_te) ||
                                ((s7_re_reg == c8_te) && (s7_mr_reg <= tol_reg.m));
                end
            end
            default: c8_within = 1'b0;
        endcase
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (adv[1])
        begin
            s1_a_reg <= classify(a_sign_exponent, a_significand);
            s1_b_reg <= classify(b_sign_exponent, b_significand);
        end
        if (adv[2])
        begin
            s2_a_reg <= normalise(s1_a_reg);
            s2_b_reg <= normalise(s1_b_reg);
        end
        if (adv[3])
        begin
            s3_direct_reg <= c3_direct;
            s3_dval_reg   <= c3_dval;
            s3_sub_reg    <= (c3_hi.sgn == c3_lo.sgn);
            s3_am_reg     <= c3_hi.m;
            s3_bm_reg     <= c3_lo.m;
            s3_ae_reg     <= c3_hi.e;
            s3_kbig_reg   <= |c3_k[EXP_W:7];
            s3_k_reg      <= c3_k[6:0];
        end
        if (adv[4])
        begin
            s4_direct_reg <= s3_direct_reg;
            s4_dval_reg   <= s3_dval_reg;
            s4_sub_reg    <= s3_sub_reg;
            s4_am_reg     <= s3_am_reg;
            s4_b_reg      <= c4_sh | WIDE_W'(c4_st);
            s4_ae_reg     <= s3_ae_reg;
        end
        if (adv[5])
        begin
            s5_direct_reg <= s4_direct_reg;
            s5_dval_reg   <= s4_dval_reg;
            s5_sum_reg    <= c5_sum;
            s5_ae_reg     <= s4_ae_reg;
        end
        if (adv[6])
        begin
            s6_direct_reg <= s5_direct_reg;
            s6_dval_reg   <= s5_dval_reg;
            s6_zero_reg   <= (s5_sum_reg == '0);
            s6_sum_reg    <= s5_sum_reg;
            s6_l_reg      <= lzc128(s5_sum_reg);
            s6_ae_reg     <= s5_ae_reg;
        end
        if (adv[7])
        begin
            s7_direct_reg <= s6_direct_reg;
            s7_dval_reg   <= s6_dval_reg;
            s7_nz_reg     <= !s6_zero_reg;
            s7_mr_reg     <= c7_mr;
            s7_re_reg     <= 17'sd1 - $signed({10'b0, s6_l_reg}) + s6_ae_reg
                             + $signed({16'b0, c7_pinc});
        end
        if (adv[8])
        begin
            equal_reg <= s7_direct_reg ? s7_dval_reg : c8_within;
        end
    end

endmodule : extended_float_tolerant_equal_core

`default_nettype wire

// ===== design/eftec_checker.sv =====
// ---------------------------------------------------------------------------
// eftec_checker
// Port-level assertions for the tolerant equality compare, bound to the
// extended_float_tolerant_equal_core module.
// ---------------------------------------------------------------------------
`default_nettype none

module eftec_checker (
    input wire logic                        clk,
    input wire logic                        rst_n,
    input wire logic                        in_valid,
    input wire logic                        in_stall,
    input wire logic [eftec_pkg::SE_W-1:0]  a_sign_exponent,
    input wire logic [eftec_pkg::SIG_W-1:0] a_significand,
    input wire logic [eftec_pkg::SE_W-1:0]  b_sign_exponent,
    input wire logic [eftec_pkg::SIG_W-1:0] b_significand,
    input wire logic                        out_valid,
    input wire logic                        out_stall,
    input wire logic                        equal
);
    import eftec_pkg::*;

    logic       nan_pair_in;
    logic       no_stall_run;
    logic [7:1] stall_hist_reg;

    assign nan_pair_in = in_valid && !in_stall &&
                         (a_sign_exponent[14:0] == EX_MAX) && (a_significand != TOPBIT) &&
                         (b_sign_exponent[14:0] == EX_MAX) && (b_significand != TOPBIT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stall_hist_reg <= '1;
        end
        else
        begin
            stall_hist_reg <= {stall_hist_reg[6:1], out_stall};
        end
    end

    assign no_stall_run = !(|stall_hist_reg);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(equal))
        else $error("stalled result changed");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled while output free");

    a_nan_pair: assert property (@(posedge clk) disable iff (!rst_n)
        $past(nan_pair_in, 8) && no_stall_run |-> out_valid && equal)
        else $error("two NaNs not reported equal");

    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $past(in_valid && !in_stall, 8) && no_stall_run |-> out_valid)
        else $error("result missing after pipeline latency");

endmodule : eftec_checker

bind extended_float_tolerant_equal_core eftec_checker u_eftec_checker (.*);

`default_nettype wire

// ===== sim/tb_extended_float_tolerant_equal_core.sv =====
// ---------------------------------------------------------------------------
// tb_extended_float_tolerant_equal_core
// Self-checking testbench for the tolerant equality compare of two x87
// 80-bit extended values.
// ---------------------------------------------------------------------------
// Pairs of values are sent over the valid/stall input channel while the
// output channel is, in some phases, stalled at random. Each accepted pair is scored by a
// predictor inside this bench, and every equal flag is checked in order.
// The tolerance is reprogrammed between phases with the pipeline idle.
`default_nettype none

module tb_extended_float_tolerant_equal_core;

    timeunit 1ns;
    timeprecision 1ps;

    import eftec_pkg::*;

    localparam logic [63:0] INT_BIT = 64'h8000_0000_0000_0000;
    localparam int DRAIN_CYCLES = 12;

    typedef struct {
        cls_t      cls;
        bit        sgn;
        bit [63:0] m;
        int        e;
    } ext_t;

    typedef struct {
        logic [15:0] ase;
        logic [63:0] asig;
        logic [15:0] bse;
        logic [63:0] bsig;
        bit          eq;
    } pair_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [15:0] a_sign_exponent = '0;
    logic [63:0] a_significand = '0;
    logic [15:0] b_sign_exponent = '0;
    logic [63:0] b_significand = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic        equal;
    logic        cfg_write = 1'b0;
    logic        cfg_index = 1'b0;
    logic [63:0] cfg_data = '0;

    bit [15:0] tol_se = '0;
    bit [63:0] tol_sig = '0;
    pair_t     expected_flags[$];
    int        mismatches = 0;
    int        flags_checked = 0;
    int        pairs_sent = 0;
    int        tolerances_used = 0;
    bit        idle_on = 1'b0;
    bit        stall_on = 1'b0;
    logic      long_hold = 1'b0;
    int        stall_left = 0;

    extended_float_tolerant_equal_core u_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .a_sign_exponent (a_sign_exponent),
        .a_significand   (a_significand),
        .b_sign_exponent (b_sign_exponent),
        .b_significand   (b_significand),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .equal           (equal),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #5 clk = ~clk;

    function automatic ext_t decode_ext(input bit [15:0] se, input bit [63:0] m);
        ext_t v;
        bit [14:0] ex;
        ex = se[14:0];
        v.sgn = se[15];
        v.m = m;
        v.e = 0;
        if (ex == 15'h7fff)
        begin
            v.cls = (m == INT_BIT) ? CL_INF : CL_NAN;
        end
        else if (ex == 15'd0)
        begin
            if (m == '0)
            begin
                v.cls = CL_ZERO;
            end
            else if (m[63])
            begin
                v.cls = CL_NAN;
            end
            else
            begin
                v.cls = CL_FIN;
                v.e = -16381;
                while (!v.m[63])
                begin
                    v.m = v.m << 1;
                    v.e--;
                end
            end
        end
        else if (!m[63])
        begin
            v.cls = CL_NAN;
        end
        else
        begin
            v.cls = CL_FIN;
            v.e = int'(ex) - 16382;
        end
        return v;
    endfunction

    function automatic bit unit_bounded(input ext_t v);
        if (v.cls == CL_ZERO)
        begin
            return 1'b1;
        end
        return (v.e <= 0) || (v.e == 1 && v.m == INT_BIT);
    endfunction

    // Rounded magnitude of the difference x - y. Returns 0 for an exact zero.
    function automatic bit round_diff(input ext_t x, input ext_t y,
                                      output bit [63:0] rm, output int re);
        ext_t      big, sml;
        bit [63:0] ahi, alo, bhi, blo, hi, lo, st, mr, guard, sticky;
        int        k, p, s;
        rm = '0;
        re = 0;
        st = '0;
        if (x.cls == CL_ZERO && y.cls == CL_ZERO)
        begin
            return 1'b0;
        end
        if (x.cls == CL_ZERO)
        begin
            rm = y.m;
            re = y.e;
            return 1'b1;
        end
        if (y.cls == CL_ZERO)
        begin
            rm = x.m;
            re = x.e;
            return 1'b1;
        end
        if (x.e > y.e || (x.e == y.e && x.m >= y.m))
        begin
            big = x;
            sml = y;
        end
        else
        begin
            big = y;
            sml = x;
        end
        k = big.e - sml.e;
        ahi = big.m >> 1;
        alo = big.m << 63;
        bhi = sml.m >> 1;
        blo = sml.m << 63;
        if (k >= 128)
        begin
            bhi = '0;
            blo = '0;
            st = 64'd1;
        end
        else if (k >= 64)
        begin
            s = k - 64;
            st = 64'(blo != 0);
            if (s > 0)
            begin
                if ((bhi & ((64'd1 << s) - 64'd1)) != 0)
                begin
                    st = 64'd1;
                end
                blo = bhi >> s;
            end
            else
            begin
                blo = bhi;
            end
            bhi = '0;
        end
        else if (k > 0)
        begin
            if ((blo & ((64'd1 << k) - 64'd1)) != 0)
            begin
                st = 64'd1;
            end
            blo = (blo >> k) | (bhi << (64 - k));
            bhi = bhi >> k;
        end
        blo = blo | st;
        if (x.sgn != y.sgn)
        begin
            {hi, lo} = {ahi, alo} + {bhi, blo};
        end
        else
        begin
            {hi, lo} = {ahi, alo} - {bhi, blo};
        end
        if (hi == 0 && lo == 0)
        begin
            return 1'b0;
        end
        if (hi != 0)
        begin
            p = 127;
            while (!hi[p-64])
            begin
                p--;
            end
        end
        else
        begin
            p = 63;
            while (!lo[p])
            begin
                p--;
            end
        end
        if (p >= 63)
        begin
            s = p - 63;
            if (s == 0)
            begin
                mr = lo;
            end
            else
            begin
                mr = (s == 64) ? hi : ((lo >> s) | (hi << (64 - s)));
                guard = (lo >> (s - 1)) & 64'd1;
                sticky = lo & ((64'd1 << (s - 1)) - 64'd1);
                if (guard != 0 && (sticky != 0 || mr[0]))
                begin
                    mr++;
                    if (mr == 0)
                    begin
                        mr = INT_BIT;
                        p++;
                    end
                end
            end
        end
        else
        begin
            mr = lo << (63 - p);
        end
        rm = mr;
        re = p + big.e - 126;
        return 1'b1;
    endfunction

    function automatic bit tol_accepts(input bit nonzero, input bit [63:0] rm, input int re);
        ext_t t;
        t = decode_ext(tol_se, tol_sig);
        if (t.cls == CL_NAN)
        begin
            return 1'b0;
        end
        if (t.cls == CL_INF)
        begin
            return !t.sgn;
        end
        if (t.cls == CL_ZERO)
        begin
            return !nonzero;
        end
        if (t.sgn)
        begin
            return 1'b0;
        end
        if (!nonzero)
        begin
            return 1'b1;
        end
        return (re < t.e + 1) || (re == t.e + 1 && rm <= t.m);
    endfunction

    function automatic bit expect_equal(input pair_t pr);
        ext_t      a, b;
        bit [63:0] rm;
        int        re, lo_e;
        bit        nz;
        a = decode_ext(pr.ase, pr.asig);
        b = decode_ext(pr.bse, pr.bsig);
        if (a.cls == CL_NAN && b.cls == CL_NAN)
        begin
            return 1'b1;
        end
        if (a.cls == CL_NAN || b.cls == CL_NAN)
        begin
            return 1'b0;
        end
        if (a.cls == CL_INF && b.cls == CL_INF)
        begin
            return a.sgn == b.sgn;
        end
        if (a.cls == CL_INF || b.cls == CL_INF)
        begin
            return 1'b0;
        end
        if (unit_bounded(a) && unit_bounded(b))
        begin
            nz = round_diff(a, b, rm, re);
            return tol_accepts(nz, rm, re);
        end
        if (a.sgn != b.sgn)
        begin
            return 1'b0;
        end
        if (a.e - b.e > 1 || b.e - a.e > 1)
        begin
            return 1'b0;
        end
        lo_e = (a.e < b.e) ? a.e : b.e;
        a.e = a.e - lo_e;
        b.e = b.e - lo_e;
        nz = round_diff(a, b, rm, re);
        return tol_accepts(nz, rm, re);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end
        else if (long_hold)
        begin
            out_stall <= 1'b1;
        end
        else if (stall_on && $urandom_range(0, 5) == 0)
        begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end
        else
        begin
            out_stall <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        pair_t pr;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_flags.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("[%0t] equal flag %0b arrived with no pair outstanding", $time, equal);
                end
            end
            else
            begin
                pr = expected_flags.pop_front();
                flags_checked++;
                if (equal !== pr.eq)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("[%0t] a=%h:%h b=%h:%h tol=%h:%h expected %0b got %b",
                                 $time, pr.ase, pr.asig, pr.bse, pr.bsig,
                                 tol_se, tol_sig, pr.eq, equal);
                    end
                end
            end
        end
    end

    task automatic send_pair(input logic [15:0] ase, input logic [63:0] asig,
                             input logic [15:0] bse, input logic [63:0] bsig);
        pair_t pr;
        if (idle_on && $urandom_range(0, 4) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        a_sign_exponent <= ase;
        a_significand <= asig;
        b_sign_exponent <= bse;
        b_significand <= bsig;
        in_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (in_stall);
        pr.ase = ase;
        pr.asig = asig;
        pr.bse = bse;
        pr.bsig = bsig;
        pr.eq = expect_equal(pr);
        expected_flags.push_back(pr);
        pairs_sent++;
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (expected_flags.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [63:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
    endtask

    task automatic set_tolerance(input logic [15:0] se, input logic [63:0] sig);
        wait_drained();
        write_reg(REG_TOL_SE, {48'd0, se});
        write_reg(REG_TOL_SIG, sig);
        cfg_write <= 1'b0;
        tol_se = se;
        tol_sig = sig;
        tolerances_used++;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic random_pair(output logic [15:0] ase, output logic [63:0] asig,
                               output logic [15:0] bse, output logic [63:0] bsig);
        logic [63:0] delta;
        int          kind;
        kind = $urandom_range(0, 9);
        ase = 16'(rand64());
        asig = rand64();
        bse = 16'(rand64());
        bsig = rand64();
        if (kind <= 6)
        begin
            if (kind <= 3)
            begin
                ase[14:0] = 15'd16383 - 15'($urandom_range(0, 12));
            end
            else if (kind == 4)
            begin
                ase[14:0] = 15'($urandom_range(1, 32766));
            end
            else
            begin
                ase[14:0] = 15'd0;
            end
            if (ase[14:0] != 0)
            begin
                asig[63] = 1'b1;
            end
            else
            begin
                asig[63] = 1'b0;
            end
            delta = 64'($urandom_range(0, 40)) << $urandom_range(0, 63);
            bse = ase;
            bsig = $urandom_range(0, 1) ? asig + delta : asig - delta;
            if ($urandom_range(0, 3) == 0)
            begin
                bse[14:0] = ase[14:0] + ($urandom_range(0, 1) ? 15'd1 : -15'd1);
                bsig = ~bsig;
            end
            if ((bse[14:0] != 0 && bse[14:0] != 15'h7fff) && $urandom_range(0, 7) != 0)
            begin
                bsig[63] = 1'b1;
            end
            if ($urandom_range(0, 7) == 0)
            begin
                bse[15] = ~ase[15];
            end
            if ($urandom_range(0, 1))
            begin
                {ase, asig, bse, bsig} = {bse, bsig, ase, asig};
            end
        end
        else if (kind == 7)
        begin
            ase[14:0] = $urandom_range(0, 1) ? 15'h7fff : 15'd0;
            asig = $urandom_range(0, 1) ? INT_BIT : asig;
        end
    endtask

    task automatic run_random(input int count);
        logic [15:0] ase, bse;
        logic [63:0] asig, bsig;
        repeat (count)
        begin
            random_pair(ase, asig, bse, bsig);
            send_pair(ase, asig, bse, bsig);
        end
    endtask

    task automatic test_reset_tolerance();
        send_pair(16'h3fff, INT_BIT, 16'h3fff, INT_BIT);
        send_pair(16'h3fff, INT_BIT, 16'h3fff, INT_BIT + 64'd1);
        send_pair(16'h0000, 64'd0, 16'h8000, 64'd0);
    endtask

    task automatic test_directed();
        set_tolerance(16'h3fc3, INT_BIT);
        send_pair(16'h0000, 64'd0, 16'h8000, 64'd0);
        send_pair(16'h3fff, INT_BIT, 16'hbfff, INT_BIT);
        send_pair(16'h3fff, INT_BIT, 16'h3ffe, 64'hffff_ffff_ffff_ffff);
        send_pair(16'h4000, INT_BIT, 16'h4000, INT_BIT + 64'd1);
        send_pair(16'h4000, INT_BIT, 16'h4002, INT_BIT);
        send_pair(16'h4000, INT_BIT, 16'hc000, INT_BIT);
        send_pair(16'h0000, 64'd1, 16'h0000, 64'd2);
        send_pair(16'h7ffe, '1, 16'h7ffe, '1);
        send_pair(16'h7fff, INT_BIT, 16'h7fff, INT_BIT);
        send_pair(16'h7fff, INT_BIT, 16'hffff, INT_BIT);
        send_pair(16'h7fff, INT_BIT, 16'h4000, INT_BIT);
        send_pair(16'h7fff, 64'hc000_0000_0000_0000, 16'hffff, 64'd1);
        send_pair(16'h7fff, 64'hc000_0000_0000_0000, 16'h3fff, INT_BIT);
        send_pair(16'h7fff, 64'd0, 16'h7fff, INT_BIT);
        send_pair(16'h3fff, 64'h4000_0000_0000_0000, 16'h3fff, 64'h4000_0000_0000_0000);
        send_pair(16'h0000, INT_BIT, 16'h0000, 64'd0);
        send_pair(16'hffff, '1, 16'h0000, '1);
        send_pair(16'h4000, '1, 16'h4001, INT_BIT);
        send_pair(16'h0000, 64'd0, 16'h3fbf, INT_BIT);
        send_pair(16'hbffe, INT_BIT, 16'h3ffe, INT_BIT);
    endtask

    task automatic test_tolerance_sweep();
        logic [15:0] tse[10];
        logic [63:0] tsig[10];
        tse  = '{16'h3feb, 16'h3ffe, 16'hbffe, 16'h7fff, 16'hffff,
                 16'h7fff, 16'h0000, 16'h7ffe, 16'h3fff, 16'h3fc1};
        tsig = '{rand64() | INT_BIT, INT_BIT, INT_BIT, INT_BIT, INT_BIT,
                 '1, 64'd1, '1, 64'd0, 64'h8000_0000_0000_0001};
        for (int i = 0; i < 10; i++)
        begin
            set_tolerance(tse[i], tsig[i]);
            idle_on = (i % 3) != 2;
            stall_on = (i % 3) != 1;
            run_random(130);
        end
        set_tolerance(16'h0000, 64'd0);
        run_random(60);
    endtask

    task automatic test_backpressure();
        set_tolerance(16'h3fc3, INT_BIT);
        idle_on = 1'b0;
        fork
            begin
                long_hold <= 1'b1;
                repeat (200) @(posedge clk);
                long_hold <= 1'b0;
            end
        join_none
        run_random(60);
        wait_drained();
        run_random(30);
    endtask

    task automatic test_full_rate();
        set_tolerance(16'h3fe0, rand64() | INT_BIT);
        idle_on = 1'b0;
        stall_on = 1'b0;
        run_random(100);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_tolerance();
        test_directed();
        test_tolerance_sweep();
        test_backpressure();
        test_full_rate();
        wait_drained();
        $display("Sent %0d pairs and checked %0d equal flags over %0d tolerance settings,",
                 pairs_sent, flags_checked, tolerances_used);
        $display("covering special encodings, output stalls and a full pipeline.");
        if (mismatches == 0 && expected_flags.size() == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial
    begin
        #5ms;
        $display("Timed out with %0d flags outstanding", expected_flags.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/eftec_pkg.sv
design/extended_float_tolerant_equal_core.sv
design/eftec_checker.sv
sim/tb_extended_float_tolerant_equal_core.sv
